[src/greedy_box_suppression_defines.svh]
// ----------------------------------------------------------------------------
// Greedy box suppression assertion macros
// Shared assertion shorthands, clocked on aclk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_DEFINES_SVH

// Condition that must hold at every clock edge.
`define GBS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define GBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

[src/gbs_pkg.sv]
// ----------------------------------------------------------------------------
// Greedy box suppression package
// Sizes, register map, controller states and the structs shared by modules.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MAX_KEPT   = 64;
    localparam int MAX_ITEMS  = 4096;
    localparam int COORD_BITS = 16;

    localparam int FIELD_W  = 16;
    localparam int THR_W    = 16;
    localparam int COORD_W  = COORD_BITS;
    localparam int AREA_W   = 2 * COORD_W;
    localparam int UNION_W  = AREA_W + 1;
    localparam int PROD_W   = UNION_W + THR_W;
    localparam int ENTRY_W  = 4 * COORD_W + AREA_W;
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int ITEM_W   = $clog2(MAX_ITEMS);

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic [THR_W-1:0] IOU_THRESHOLD_RESET = 16'd29491;
    localparam logic REG_IOU_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } gbs_state_t;

    typedef struct packed {
        logic capture;
        logic issue;
        logic commit;
    } gbs_cmd_t;

    typedef struct packed {
        logic             more;
        logic             pipe_busy;
        logic             out_free;
        logic [CNT_W-1:0] kept_count;
    } gbs_status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] box_height;
        logic [FIELD_W-1:0] box_width;
        logic [FIELD_W-1:0] box_top;
        logic [FIELD_W-1:0] box_left;
    } gbs_box_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic        store_overflow;
        logic [5:0]  kept_slot;
        logic [11:0] item_number;
        logic        keep;
    } gbs_result_t;

endpackage

[src/greedy_box_suppression.sv]
// ----------------------------------------------------------------------------
// Greedy box suppression
// Greedy IoU suppression of score-sorted boxes against a store of kept boxes.
// ----------------------------------------------------------------------------
// Boxes enter on the s_ channel, one item per box, in descending score order.
// A set_start flag in s_tuser empties the kept store and restarts numbering
// with that box. One result item per box leaves on the m_ channel in order.
// The IoU threshold is to be written over the APB port only while the block
// is idle; the block itself does not enforce this. Each box is tested
// against every kept box of its set, one kept box per cycle, read from the
// kept store memory through its single read port into a five-stage overlap
// test pipeline. After the scan, the drain state waits until the pipeline is
// empty and the output register is free, then loads the result and returns
// to idle, where the next box is accepted; no new box is taken while one is
// in flight.
// A result waiting in the output register does not block the next item;
// if the receiver stalls, the block holds the following result in its
// drain state until the output register frees.
// Reset clears the kept count, the item numbering and the result valid, and
// loads the default threshold; the store contents need no clearing.
// ----------------------------------------------------------------------------
`include "greedy_box_suppression_defines.svh"

module greedy_box_suppression (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,  // box_left, box_top, box_width, box_height
    input  logic                         s_tuser,  // set_start
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,  // keep, item_number, kept_slot,
                                                   // store_overflow, zero pad
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbs_pkg::PADDR_W-1:0]  paddr,
    input  logic [gbs_pkg::PDATA_W-1:0]  pwdata,
    output logic [gbs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    logic [gbs_pkg::THR_W-1:0] iou_threshold_reg;
    gbs_pkg::gbs_cmd_t         cmd;
    gbs_pkg::gbs_status_t      status;
    gbs_pkg::gbs_result_t      result;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iou_threshold_reg <= gbs_pkg::IOU_THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == gbs_pkg::REG_IOU_THRESHOLD)) begin
            iou_threshold_reg <= pwdata[gbs_pkg::THR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == gbs_pkg::REG_IOU_THRESHOLD) ?
                    gbs_pkg::PDATA_W'(iou_threshold_reg) : '0;

    gbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gbs_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .box_in        (gbs_pkg::gbs_box_t'(s_tdata)),
        .set_start     (s_tuser),
        .iou_threshold (iou_threshold_reg),
        .cmd           (cmd),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .result        (result)
    );

    assign m_tdata = result;

    `GBS_ASSERT_ALWAYS(a_count_bound, status.kept_count <= gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT), "kept count beyond store size")
    `GBS_ASSERT_ALWAYS(a_capture_alone, !(cmd.capture && (status.pipe_busy || cmd.commit)), "item captured while another is in flight")
    `GBS_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid, "commit did not present a result")
    `GBS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item accepted during processing")

endmodule

[src/gbs_ctrl.sv]
// ----------------------------------------------------------------------------
// Greedy box suppression controller
// Sequences capture, the scan over the kept store, the drain and the commit.
// ----------------------------------------------------------------------------
module gbs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  gbs_pkg::gbs_status_t status,
    output gbs_pkg::gbs_cmd_t    cmd
);

    gbs_pkg::gbs_state_t state_reg;
    gbs_pkg::gbs_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gbs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = gbs_pkg::ST_SCAN;
                end
            end
            gbs_pkg::ST_SCAN: begin
                if (!status.more) begin
                    state_next = gbs_pkg::ST_DRAIN;
                end
            end
            gbs_pkg::ST_DRAIN: begin
                if (!status.pipe_busy && status.out_free) begin
                    state_next = gbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.issue   = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            gbs_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            gbs_pkg::ST_SCAN: begin
                cmd.issue = status.more;
            end
            gbs_pkg::ST_DRAIN: begin
                cmd.commit = !status.pipe_busy && status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[src/gbs_datapath.sv]
// ----------------------------------------------------------------------------
// Greedy box suppression datapath
// Holds the current box, the kept store memory, the overlap test pipeline,
// the set counters and the result register.
// ----------------------------------------------------------------------------
module gbs_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  gbs_pkg::gbs_box_t                box_in,
    input  logic                             set_start,
    input  logic [gbs_pkg::THR_W-1:0]        iou_threshold,
    input  gbs_pkg::gbs_cmd_t                cmd,
    output gbs_pkg::gbs_status_t             status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output gbs_pkg::gbs_result_t             result
);

    localparam int CW = gbs_pkg::COORD_W;
    localparam int AW = gbs_pkg::AREA_W;

    function automatic logic [CW-1:0] overlap(
        input logic [CW:0] a0,
        input logic [CW:0] a1,
        input logic [CW:0] b0,
        input logic [CW:0] b1
    );
        logic [CW:0] lo;
        logic [CW:0] hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        overlap = (hi > lo) ? CW'(hi - lo) : '0;
    endfunction

    logic [CW-1:0]                 left_reg;
    logic [CW-1:0]                 top_reg;
    logic [CW-1:0]                 width_reg;
    logic [CW-1:0]                 height_reg;
    logic [AW-1:0]                 area_reg;
    logic [gbs_pkg::ITEM_W-1:0]    number_reg;
    logic [gbs_pkg::ITEM_W-1:0]    counter_reg;
    logic [gbs_pkg::CNT_W-1:0]     count_reg;
    logic [gbs_pkg::CNT_W-1:0]     addr_reg;
    logic                          suppressed_reg;

    logic [gbs_pkg::ENTRY_W-1:0]   mem [gbs_pkg::MAX_KEPT];
    logic [gbs_pkg::ENTRY_W-1:0]   rd_reg;
    logic                          v1_reg;
    logic                          v2_reg;
    logic                          v3_reg;
    logic                          v4_reg;
    logic                          v5_reg;
    logic [CW-1:0]                 iw_reg;
    logic [CW-1:0]                 ih_reg;
    logic [AW-1:0]                 karea2_reg;
    logic [AW-1:0]                 inter3_reg;
    logic [AW-1:0]                 karea3_reg;
    logic [AW-1:0]                 inter4_reg;
    logic [gbs_pkg::UNION_W-1:0]   union4_reg;
    logic [gbs_pkg::PROD_W-1:0]    lhs5_reg;
    logic [gbs_pkg::PROD_W-1:0]    rhs5_reg;

    logic                          out_valid_reg;
    logic                          out_keep_reg;
    logic [gbs_pkg::ITEM_W-1:0]    out_number_reg;
    logic [5:0]                    out_slot_reg;
    logic                          out_overflow_reg;

    logic [CW-1:0]                 in_left;
    logic [CW-1:0]                 in_top;
    logic [CW-1:0]                 in_width;
    logic [CW-1:0]                 in_height;
    logic [CW-1:0]                 k_left;
    logic [CW-1:0]                 k_top;
    logic [CW-1:0]                 k_width;
    logic [CW-1:0]                 k_height;
    logic [AW-1:0]                 k_area;
    logic                          kept_full;
    logic                          keep_now;
    logic                          out_free;

    assign in_left   = CW'(box_in.box_left);
    assign in_top    = CW'(box_in.box_top);
    assign in_width  = CW'(box_in.box_width);
    assign in_height = CW'(box_in.box_height);

    assign {k_area, k_height, k_width, k_top, k_left} = rd_reg;

    assign kept_full = (count_reg == gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT));
    assign keep_now  = !suppressed_reg;
    assign out_free  = !out_valid_reg || m_tready;

    assign status.more       = (addr_reg != count_reg);
    assign status.pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;
    assign status.out_free   = out_free;
    assign status.kept_count = count_reg;

    // Item capture and the per-set counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            counter_reg <= '0;
        end else begin
            if (cmd.capture) begin
                if (set_start) begin
                    count_reg   <= '0;
                    counter_reg <= gbs_pkg::ITEM_W'(1);
                end else if (counter_reg == gbs_pkg::ITEM_W'(gbs_pkg::MAX_ITEMS - 1)) begin
                    counter_reg <= '0;
                end else begin
                    counter_reg <= counter_reg + gbs_pkg::ITEM_W'(1);
                end
            end else if (cmd.commit && keep_now && !kept_full) begin
                count_reg <= count_reg + gbs_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            left_reg       <= in_left;
            top_reg        <= in_top;
            width_reg      <= in_width;
            height_reg     <= in_height;
            area_reg       <= AW'(in_width) * AW'(in_height);
            number_reg     <= set_start ? '0 : counter_reg;
            addr_reg       <= '0;
            suppressed_reg <= 1'b0;
        end else begin
            if (cmd.issue) begin
                addr_reg <= addr_reg + gbs_pkg::CNT_W'(1);
            end
            if (v5_reg && (lhs5_reg > rhs5_reg)) begin
                suppressed_reg <= 1'b1;
            end
        end
    end

    // Kept store: one write port at commit, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.commit && keep_now && !kept_full) begin
            mem[count_reg[gbs_pkg::ADDR_W-1:0]] <=
                {area_reg, height_reg, width_reg, top_reg, left_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_reg <= mem[addr_reg[gbs_pkg::ADDR_W-1:0]];
        end
    end

    // Overlap test pipeline valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // The test inter / union > threshold / 65536 is done as
    // inter * 65536 > threshold * union, exactly.
    always_ff @(posedge aclk) begin
        iw_reg     <= overlap({1'b0, left_reg}, {1'b0, left_reg} + {1'b0, width_reg},
                              {1'b0, k_left}, {1'b0, k_left} + {1'b0, k_width});
        ih_reg     <= overlap({1'b0, top_reg}, {1'b0, top_reg} + {1'b0, height_reg},
                              {1'b0, k_top}, {1'b0, k_top} + {1'b0, k_height});
        karea2_reg <= k_area;
        inter3_reg <= AW'(iw_reg) * AW'(ih_reg);
        karea3_reg <= karea2_reg;
        inter4_reg <= inter3_reg;
        union4_reg <= gbs_pkg::UNION_W'(area_reg) + gbs_pkg::UNION_W'(karea3_reg)
                      - gbs_pkg::UNION_W'(inter3_reg);
        lhs5_reg   <= gbs_pkg::PROD_W'(inter4_reg) << gbs_pkg::THR_W;
        rhs5_reg   <= gbs_pkg::PROD_W'(iou_threshold) * gbs_pkg::PROD_W'(union4_reg);
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_keep_reg     <= keep_now;
            out_number_reg   <= number_reg;
            out_slot_reg     <= (keep_now && !kept_full) ?
                                6'(count_reg[gbs_pkg::ADDR_W-1:0]) : 6'd0;
            out_overflow_reg <= keep_now && kept_full;
        end
    end

    assign m_tvalid              = out_valid_reg;
    assign result.pad            = '0;
    assign result.store_overflow = out_overflow_reg;
    assign result.kept_slot      = out_slot_reg;
    assign result.item_number    = 12'(out_number_reg);
    assign result.keep           = out_keep_reg;

endmodule

[test/greedy_box_suppression_checker.sv]
// ----------------------------------------------------------------------------
// Greedy box suppression result checker
// Watches the box, result and register channels, keeps its own copy of the
// kept store and threshold, predicts the verdict of every accepted box and
// compares each result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_box_suppression_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [63:0]                  s_tdata,  // box_left, box_top, box_width, box_height
    input  logic                         s_tuser,  // set_start
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [23:0]                  m_tdata,  // keep, item_number, kept_slot,
                                                   // store_overflow, zero pad
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbs_pkg::PADDR_W-1:0]  paddr,
    input  logic [gbs_pkg::PDATA_W-1:0]  pwdata,
    input  logic [gbs_pkg::PDATA_W-1:0]  prdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           outstanding
);

    import gbs_pkg::*;

    localparam logic [PADDR_W-1:0] THR_ADDR = PADDR_W'(4 * REG_IOU_THRESHOLD);

    gbs_box_t          kept_box_store  [MAX_KEPT];
    logic [AREA_W-1:0] kept_area_store [MAX_KEPT];
    logic [CNT_W-1:0]  kept_total;
    logic [ITEM_W-1:0] next_number;
    logic [THR_W-1:0]  iou_thr;
    gbs_result_t       pending_verdicts[$];
    int                errors = 0;

    function automatic logic [COORD_W:0] span_overlap(
        input logic [COORD_W-1:0] a_start, a_len, b_start, b_len);
        logic [COORD_W:0] a_end, b_end, lo, hi;
        a_end = {1'b0, a_start} + {1'b0, a_len};
        b_end = {1'b0, b_start} + {1'b0, b_len};
        lo = (a_start > b_start) ? {1'b0, a_start} : {1'b0, b_start};
        hi = (a_end < b_end) ? a_end : b_end;
        return (hi > lo) ? hi - lo : '0;
    endfunction

    function automatic gbs_result_t predict_suppression(input gbs_box_t box,
                                                        input logic set_start);
        gbs_result_t       res;
        logic [AREA_W-1:0] area;
        logic [COORD_W:0]  iw, ih;
        logic [63:0]       inter, joint;
        logic              survives;
        area = AREA_W'(box.box_width) * AREA_W'(box.box_height);
        if (set_start) begin
            kept_total  = '0;
            next_number = '0;
        end
        res = '0;
        res.item_number = next_number;
        next_number = next_number + 1'b1;
        survives = 1'b1;
        for (int i = 0; i < kept_total; i++) begin
            iw = span_overlap(box.box_left, box.box_width,
                              kept_box_store[i].box_left, kept_box_store[i].box_width);
            ih = span_overlap(box.box_top, box.box_height,
                              kept_box_store[i].box_top, kept_box_store[i].box_height);
            inter = 64'(iw) * 64'(ih);
            joint = 64'(area) + 64'(kept_area_store[i]) - inter;
            if ((inter << 16) > joint * 64'(iou_thr))
                survives = 1'b0;
        end
        res.keep = survives;
        if (survives) begin
            if (kept_total >= MAX_KEPT) begin
                res.store_overflow = 1'b1;
            end else begin
                res.kept_slot = kept_total[5:0];
                kept_box_store[kept_total[ADDR_W-1:0]]  = box;
                kept_area_store[kept_total[ADDR_W-1:0]] = area;
                kept_total = kept_total + 1'b1;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        gbs_result_t got, want;
        if (!aresetn) begin
            pending_verdicts.delete();
            kept_total  = '0;
            next_number = '0;
            iou_thr     = IOU_THRESHOLD_RESET;
        end else begin
            if (psel && penable && pready && paddr == THR_ADDR) begin
                if (pwrite) begin
                    iou_thr = pwdata[THR_W-1:0];
                end else if (prdata !== PDATA_W'(iou_thr)) begin
                    $display("%0t: iou_threshold read mismatch, expected %0d, actual %0d",
                             $time, iou_thr, prdata);
                    errors++;
                end
            end
            if (s_tvalid && s_tready)
                pending_verdicts = {pending_verdicts,
                                    predict_suppression(gbs_box_t'(s_tdata), s_tuser)};
            if (m_tvalid && m_tready) begin
                got = gbs_result_t'(m_tdata);
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: result item with none expected, expected none, actual 0x%h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("keep", want.keep, got.keep);
                    check_field("item_number", want.item_number, got.item_number);
                    check_field("kept_slot", want.kept_slot, got.kept_slot);
                    check_field("store_overflow", want.store_overflow, got.store_overflow);
                    check_field("pad", want.pad, got.pad);
                end
            end
        end
        fail_count  <= errors;
        outstanding <= pending_verdicts.size();
    end

endmodule

[test/greedy_box_suppression_tb.sv]
// ----------------------------------------------------------------------------
// Greedy box suppression testbench
// Drives directed and random box sets through the block with random stalls
// on both channels, sweeps the IoU threshold over the APB port between
// phases, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_box_suppression_tb;

    import gbs_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [PADDR_W-1:0] THR_ADDR = PADDR_W'(4 * REG_IOU_THRESHOLD);

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    int                  fail_count;
    int                  outstanding;
    int                  gap_pct   = 0;
    int                  stall_pct = 0;
    int                  cycle_count = 0;

    greedy_box_suppression dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    greedy_box_suppression_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** greedy_box_suppression: FAILED **");
            $finish;
        end
    end

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic send_box(input logic [15:0] left, top, width, height,
                            input logic start);
        if ($urandom_range(199) == 0)
            wait_results_drained();
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {height, width, top, left};
        s_tuser  <= start;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic reg_access(input logic write_en, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= THR_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(negedge aclk); while (!pready);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        reg_access(1'b1, PDATA_W'(value));
        reg_access(1'b0, '0);
    endtask

    // Boxes spaced apart horizontally never overlap, so every one survives
    // and a long set runs past the end of the kept store.
    task automatic send_spread_set(input int set_len);
        logic [15:0] t, h;
        t = 16'($urandom);
        h = 16'($urandom);
        for (int k = 0; k < set_len; k++) begin
            send_box(16'(k * 512 + $urandom_range(0, 100)), t + 16'($urandom_range(0, 255)),
                     16'($urandom_range(0, 400)), h, k == 0);
        end
    endtask

    task automatic random_traffic(input int count);
        int          sent, kind, set_len, n_centers, spread, c;
        logic [15:0] cx [3];
        logic [15:0] cy [3];
        logic [15:0] bw, bh;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99);
            if (kind < 8) begin
                set_len = $urandom_range(66, 72);
                send_spread_set(set_len);
                sent += set_len;
            end else if (kind < 22) begin
                set_len = $urandom_range(1, 8);
                repeat (set_len) begin
                    send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             $urandom_range(3) == 0);
                end
                sent += set_len;
            end else begin
                set_len   = $urandom_range(1, 30);
                n_centers = $urandom_range(1, 3);
                spread    = 1 << $urandom_range(0, 12);
                bw = 16'($urandom_range(0, 4096));
                bh = 16'($urandom_range(0, 4096));
                for (int j = 0; j < 3; j++) begin
                    cx[j] = 16'($urandom);
                    cy[j] = 16'($urandom);
                end
                for (int k = 0; k < set_len; k++) begin
                    c = $urandom_range(0, n_centers - 1);
                    send_box(cx[c] + 16'($urandom_range(0, spread)),
                             cy[c] + 16'($urandom_range(0, spread)),
                             bw + 16'($urandom_range(0, spread)),
                             bh + 16'($urandom_range(0, spread)), k == 0);
                end
                sent += set_len;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct = 19;
        stall_pct <= 76;
        reg_access(1'b0, '0);

        // Zero-area boxes, extreme corners, identical, touching and
        // partly overlapping boxes, then a second set.
        send_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_box(16'h0100, 16'h0100, 16'h0100, 16'h0100, 1'b0);
        send_box(16'h0200, 16'h0100, 16'h0100, 16'h0100, 1'b0);
        send_box(16'h0110, 16'h0100, 16'h0100, 16'h0100, 1'b0);
        send_box(16'h0180, 16'h0100, 16'h0100, 16'h0100, 1'b0);
        send_box(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
        send_box(16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 1'b0);
        send_box(16'h1000, 16'h2000, 16'h0400, 16'h0300, 1'b1);
        send_box(16'h1000, 16'h2000, 16'h0400, 16'h0300, 1'b0);
        send_box(16'h1100, 16'h2100, 16'h0000, 16'h0000, 1'b0);
        send_box(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);

        // An IoU of exactly one half against a threshold of one half.
        set_threshold(16'd32768);
        send_box(16'h0000, 16'h0000, 16'h0200, 16'h0100, 1'b1);
        send_box(16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0);
        send_box(16'h0000, 16'h0000, 16'h0100, 16'h0101, 1'b0);

        set_threshold(16'd0);
        send_spread_set(68);
        send_box(16'h0010, 16'h0000, 16'h0010, 16'hFFFF, 1'b0);
        random_traffic(170);

        gap_pct = 76;
        stall_pct <= 19;
        set_threshold(16'hFFFF);
        random_traffic(170);

        gap_pct = 0;
        stall_pct <= 0;
        set_threshold(16'($urandom));
        random_traffic(170);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("** greedy_box_suppression: PASSED **");
        else
            $display("** greedy_box_suppression: FAILED **");
        $finish;
    end

endmodule
